// ===== hw/rtl/ssa_pkg.sv =====
// Shared types and constants of the stack slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package ssa_pkg;

   // Default capacity of the slot region.
   localparam int SSA_MAX_SLOTS = 64;

   // Field widths of the transaction payloads and the limit register.
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int LIMIT_W  = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BADFREE = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GROW,
      ST_FREE_CHECK,
      ST_SHRINK,
      ST_RESULT
   } ssa_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/stack_slot_allocator.sv =====
// Stack slot allocator: free map in a synchronous memory (one read, one write port) plus a sequencer.
// One transaction in flight. An allocate scans from the base for a free slot, else grows the region;
// freeing the last slot shrinks the region and also drops the free slots below it at the new end.
// The free-map memory read, one entry per cycle, sets the scan length.
// The next request is taken in the cycle after the result moves into the output register.
// Synchronous reset empties the region and sets slot_limit to 64; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stack_slot_allocator #(
   parameter int MAX_SLOTS = ssa_pkg::SSA_MAX_SLOTS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   // Request channel.
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_mode,
   input  wire logic [ssa_pkg::SLOT_W-1:0]   req_slot_index,

   // Response channel.
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [ssa_pkg::SLOT_W-1:0]        rsp_given_slot,
   output logic [ssa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ssa_pkg::COUNT_W-1:0]       rsp_slots_in_region,

   // Configuration write channel for slot_limit.
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [ssa_pkg::LIMIT_W-1:0]  csr_slot_limit
);

   import ssa_pkg::*;

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   // Width wide enough to compare port fields against the region count.
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // ------------------------------------------------------------------
   // Free-map memory. An entry is one when its slot is inside the region
   // and free. Entries are written as they enter the region (grow writes a
   // zero), and every read whose data is used lies below the region count,
   // so no never-written entry is ever used and no clearing pass is required.
   // ------------------------------------------------------------------
   logic             free_mem [MAX_SLOTS];
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_data_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= free_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   ssa_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [IDX_W-1:0]     res_given_ff, res_given_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_given_ff, rsp_given_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      slot_ff       <= slot_in;
      res_given_ff  <= res_given_in;
      res_status_ff <= res_status_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ------------------------------------------------------------------
   // Handshakes and shared decisions.
   // ------------------------------------------------------------------
   logic             req_fire;
   logic             rsp_free;
   logic             scan_last;
   logic             slot_last;
   logic             slot_in_region;
   logic             grow_ok;
   logic [CNT_W-1:0] count_dec;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // The output register can take a new result when empty or being drained.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign count_dec      = count_ff - CNT_W'(1);
   assign scan_last      = (CNT_W'(scan_ff) + CNT_W'(1)) == count_ff;
   assign slot_last      = (CNT_W'(slot_ff) + CNT_W'(1)) == count_ff;
   assign slot_in_region = CMP_W'(req_slot_index) < CMP_W'(count_ff);
   // A limit above the capacity behaves as the capacity.
   assign grow_ok        = (CMP_W'(count_ff) < CMP_W'(limit_ff)) &&
                           (count_ff < CNT_W'(MAX_SLOTS));

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_ALLOC) begin
                  state_in = (count_ff == '0) ? ST_GROW : ST_SCAN;
               end else begin
                  state_in = slot_in_region ? ST_FREE_CHECK : ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            if (rd_data_ff) begin
               state_in = ST_RESULT;
            end else if (scan_last) begin
               state_in = ST_GROW;
            end
         end
         ST_GROW: begin
            state_in = ST_RESULT;
         end
         ST_FREE_CHECK: begin
            if (!rd_data_ff && slot_last && (count_dec != '0)) begin
               state_in = ST_SHRINK;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_SHRINK: begin
            if (!(rd_data_ff && (count_dec != '0))) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath and memory control.
   // ------------------------------------------------------------------
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = 1'b0;
      count_in      = count_ff;
      scan_in       = scan_ff;
      slot_in       = slot_ff;
      res_given_in  = res_given_ff;
      res_status_in = res_status_ff;
      limit_in      = (csr_valid && csr_ready) ? csr_slot_limit : limit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_given_in  = rsp_given_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_given_in  = '0;
               res_status_in = STAT_OK;
               scan_in       = '0;
               slot_in       = IDX_W'(req_slot_index);
               if (req_mode == MODE_ALLOC) begin
                  // Start the scan at the slot nearest the base.
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end else if (slot_in_region) begin
                  rd_en   = 1'b1;
                  rd_addr = IDX_W'(req_slot_index);
               end else begin
                  res_status_in = STAT_BADFREE;
               end
            end
         end
         ST_SCAN: begin
            // rd_data_ff holds the entry of scan_ff; fetch the following one.
            rd_en   = 1'b1;
            rd_addr = scan_ff + IDX_W'(1);
            scan_in = scan_ff + IDX_W'(1);
            if (rd_data_ff) begin
               wr_en        = 1'b1;
               wr_addr      = scan_ff;
               wr_data      = 1'b0;
               res_given_in = scan_ff;
            end
         end
         ST_GROW: begin
            if (grow_ok) begin
               wr_en        = 1'b1;
               wr_addr      = IDX_W'(count_ff);
               wr_data      = 1'b0;
               res_given_in = IDX_W'(count_ff);
               count_in     = count_ff + CNT_W'(1);
            end else begin
               res_status_in = STAT_NOSPACE;
            end
         end
         ST_FREE_CHECK: begin
            if (rd_data_ff) begin
               // The slot is already free.
               res_status_in = STAT_BADFREE;
            end else if (slot_last) begin
               // Freeing the last slot shrinks the region; look at the new end.
               count_in = count_dec;
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(count_dec - CNT_W'(1));
            end else begin
               wr_en   = 1'b1;
               wr_addr = slot_ff;
               wr_data = 1'b1;
            end
         end
         ST_SHRINK: begin
            // rd_data_ff holds the entry at the current end of the region.
            if (rd_data_ff) begin
               wr_en    = 1'b1;
               wr_addr  = IDX_W'(count_dec);
               wr_data  = 1'b0;
               count_in = count_dec;
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(count_dec - CNT_W'(1));
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_given_in  = SLOT_W'(res_given_ff);
               rsp_status_in = res_status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_given_slot      = rsp_given_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slots_in_region = rsp_count_ff;

`ifndef SYNTHESIS
   // The region never holds more slots than the memory has entries.
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SLOTS))
      else $error("region count exceeds capacity");

   // Marking a slot free only ever touches a slot inside the region.
   a_free_mark_in_region: assert property (@(posedge clock) disable iff (reset)
      (wr_en && wr_data) |-> (CNT_W'(wr_addr) < count_ff))
      else $error("free mark outside the region");

   // An idle cycle leaves the region count untouched.
   a_idle_holds_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("region count changed while idle");

   // A new response is only produced out of the result state.
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |-> $past(state_ff == ST_RESULT))
      else $error("response loaded outside the result state");

   // An accepted request always leaves the idle state.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start");
`endif

endmodule

`default_nettype wire
